### hdl/sirt_pkg.sv
package sirt_pkg;

	// Fixed field widths.
	localparam int CHAR_W    = 8;
	localparam int DIGIT_W   = 4;
	localparam int BASE_W    = 5;
	localparam int CFG_W     = 64;
	localparam int ALPHA_W   = 2 * CFG_W;
	localparam int CFG_IDX_W = 2;
	localparam int MIN_BASE  = 2;

	// Characters that take part in the alphabet check and the sign.
	localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
	localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
	localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
	localparam logic [CHAR_W-1:0] CH_TILDE = 8'h7E;
	localparam logic [CHAR_W-1:0] CH_NONE  = 8'h00;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_BASE_LENGTH   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ALPHABET_LOW  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ALPHABET_HIGH = 2'd2;

	// Reset values of the configuration registers.
	localparam logic [BASE_W-1:0] BASE_RST      = 5'd10;
	localparam logic [CFG_W-1:0]  ALPHA_LOW_RST = 64'h3736_3534_3332_3130;
	localparam logic [CFG_W-1:0]  ALPHA_HI_RST  = 64'h0000_0000_0000_3938;

	// Status of the alphabet checker.
	typedef struct packed {
		logic done;
		logic bad;
	} chk_status_t;

	// Status of the serial divider.
	typedef struct packed {
		logic               digit_done;
		logic               quot_zero;
		logic [DIGIT_W-1:0] digit;
	} div_status_t;

	// Character k of the alphabet.
	function automatic logic [CHAR_W-1:0] alpha_char(input logic [ALPHA_W-1:0] alpha,
		input logic [DIGIT_W-1:0] k);
		return alpha[{k, 3'b000} +: CHAR_W];
	endfunction

endpackage

### hdl/signed_int_to_radix_text.sv
// Channel   Handshake              Payload
// input     in_valid / in_ready    value
// output    out_valid / out_ready  out_char, is_last, base_invalid
// config    cfg_we                 cfg_addr, cfg_wdata
//
// One number at a time. The alphabet checker tests one character per cycle, up to
// base_length characters. The serial divider then forms the digits, least significant
// first, into the digit RAM, and each digit drains from the RAM through the S_READ and
// S_EMIT states, most significant first.
// Reset clears the control state and loads the default radix and alphabet.
// A stalled output holds the sequencer at the next character; no input is taken until
// the last character of the number has been handed to the output register.
module signed_int_to_radix_text import sirt_pkg::*; #(
	parameter int MAX_BASE   = 16,
	parameter int VALUE_BITS = 32
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic signed [VALUE_BITS-1:0] value,
	input  logic                         cfg_we,
	input  logic [CFG_IDX_W-1:0]         cfg_addr,
	input  logic [CFG_W-1:0]             cfg_wdata,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [CHAR_W-1:0]            out_char,
	output logic                         is_last,
	output logic                         base_invalid
);

	localparam int ADDR_W = $clog2(VALUE_BITS);
	localparam int CNT_W  = $clog2(VALUE_BITS + 1);

	typedef enum logic [2:0] {
		S_IDLE,
		S_CHECK,
		S_ERROR,
		S_SIGN,
		S_DIVIDE,
		S_READ,
		S_EMIT
	} state_t;

	state_t                state_q;
	logic [BASE_W-1:0]     base_length_q;
	logic [CFG_W-1:0]      alpha_low_q;
	logic [CFG_W-1:0]      alpha_high_q;
	logic [ALPHA_W-1:0]    alphabet;
	logic [VALUE_BITS-1:0] value_q;
	logic [CNT_W-1:0]      cnt_q;
	logic [CNT_W-1:0]      cnt_inc;
	logic                  in_xact;
	logic                  slot_free;
	logic                  negative;
	logic [VALUE_BITS-1:0] mag;
	logic                  div_load;
	logic                  div_run;
	logic                  ram_re;
	logic [DIGIT_W-1:0]    ram_rdata;
	logic [ADDR_W-1:0]     ram_raddr;
	chk_status_t           chk;
	div_status_t           div;

	assign alphabet  = {alpha_high_q, alpha_low_q};
	assign in_ready  = (state_q == S_IDLE);
	assign in_xact   = in_valid && in_ready;
	assign slot_free = !out_valid || out_ready;

	// Magnitude of the number; the most negative value maps onto the sign bit alone.
	assign negative = value_q[VALUE_BITS-1];
	assign mag      = negative ? (~value_q + 1'b1) : value_q;

	assign div_load  = (state_q == S_SIGN) && (!negative || slot_free);
	assign div_run   = (state_q == S_DIVIDE);
	assign cnt_inc   = cnt_q + 1'b1;
	assign ram_re    = (state_q == S_READ);
	assign ram_raddr = ADDR_W'(cnt_q - 1'b1);

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_length_q <= BASE_RST;
			alpha_low_q   <= ALPHA_LOW_RST;
			alpha_high_q  <= ALPHA_HI_RST;
		end else if (cfg_we) begin
			case (cfg_addr)
				REG_BASE_LENGTH:   base_length_q <= cfg_wdata[BASE_W-1:0];
				REG_ALPHABET_LOW:  alpha_low_q   <= cfg_wdata;
				REG_ALPHABET_HIGH: alpha_high_q  <= cfg_wdata;
				default:           ;
			endcase
		end
	end

	// The accepted number is held for the sign step.
	always_ff @(posedge clk) begin
		if (in_xact) begin
			value_q <= value;
		end
	end

	sirt_alpha_check #(
		.MAX_BASE(MAX_BASE)
	) u_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (in_xact),
		.base_length(base_length_q),
		.alphabet   (alphabet),
		.status     (chk)
	);

	sirt_divider #(
		.VALUE_BITS(VALUE_BITS)
	) u_divider (
		.clk   (clk),
		.arst_n(arst_n),
		.load  (div_load),
		.mag   (mag),
		.run   (div_run),
		.radix (base_length_q),
		.status(div)
	);

	sirt_digit_ram #(
		.DEPTH(VALUE_BITS)
	) u_ram (
		.clk  (clk),
		.we   (div.digit_done),
		.waddr(cnt_q[ADDR_W-1:0]),
		.wdata(div.digit),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// Sequencer and output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			cnt_q        <= '0;
			out_valid    <= 1'b0;
			out_char     <= CH_NONE;
			is_last      <= 1'b0;
			base_invalid <= 1'b0;
		end else begin
			if (out_ready) begin
				out_valid <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_xact) begin
						state_q <= S_CHECK;
					end
				end
				S_CHECK: begin
					if (chk.done) begin
						state_q <= chk.bad ? S_ERROR : S_SIGN;
					end
				end
				S_ERROR: begin
					if (slot_free) begin
						out_valid    <= 1'b1;
						out_char     <= CH_NONE;
						is_last      <= 1'b1;
						base_invalid <= 1'b1;
						state_q      <= S_IDLE;
					end
				end
				S_SIGN: begin
					if (div_load) begin
						cnt_q   <= '0;
						state_q <= S_DIVIDE;
					end
					if (negative && slot_free) begin
						out_valid    <= 1'b1;
						out_char     <= CH_MINUS;
						is_last      <= 1'b0;
						base_invalid <= 1'b0;
					end
				end
				S_DIVIDE: begin
					if (div.digit_done) begin
						cnt_q <= cnt_inc;
						if (div.quot_zero || (cnt_inc == CNT_W'(VALUE_BITS))) begin
							state_q <= S_READ;
						end
					end
				end
				S_READ: begin
					cnt_q   <= cnt_q - 1'b1;
					state_q <= S_EMIT;
				end
				S_EMIT: begin
					if (slot_free) begin
						out_valid    <= 1'b1;
						out_char     <= alpha_char(alphabet, ram_rdata);
						is_last      <= (cnt_q == '0);
						base_invalid <= 1'b0;
						state_q      <= (cnt_q == '0) ? S_IDLE : S_READ;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

### hdl/sirt_alpha_check.sv
module sirt_alpha_check import sirt_pkg::*; #(
	parameter int MAX_BASE = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [BASE_W-1:0]  base_length,
	input  logic [ALPHA_W-1:0] alphabet,
	output chk_status_t        status
);

	logic               busy_q;
	logic [DIGIT_W-1:0] idx_q;
	logic [CHAR_W-1:0]  cur_char;
	logic               range_bad;
	logic               char_bad;
	logic               dup;
	logic               last;

	// The radix must lie within the supported range.
	assign range_bad = (base_length < BASE_W'(MIN_BASE)) || (base_length > BASE_W'(MAX_BASE));

	// One character is tested per cycle against its printable range and the signs.
	assign cur_char = alpha_char(alphabet, idx_q);
	assign char_bad = (cur_char == CH_PLUS) || (cur_char == CH_MINUS) ||
		(cur_char < CH_SPACE) || (cur_char > CH_TILDE);

	// Compare the current character with every character before it.
	always_comb begin
		dup = 1'b0;
		for (int j = 0; j < MAX_BASE; j++) begin
			if ((DIGIT_W'(j) < idx_q) && (alpha_char(alphabet, DIGIT_W'(j)) == cur_char)) begin
				dup = 1'b1;
			end
		end
	end

	assign last = ({1'b0, idx_q} == (base_length - 1'b1));

	assign status.bad  = range_bad || char_bad || dup;
	assign status.done = busy_q && (status.bad || last);

	// Walk through the characters in use.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			idx_q  <= '0;
		end else if (busy_q) begin
			if (status.done) begin
				busy_q <= 1'b0;
			end
			idx_q <= idx_q + 1'b1;
		end
	end

endmodule

### hdl/sirt_divider.sv
module sirt_divider import sirt_pkg::*; #(
	parameter int VALUE_BITS = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  load,
	input  logic [VALUE_BITS-1:0] mag,
	input  logic                  run,
	input  logic [BASE_W-1:0]     radix,
	output div_status_t           status
);

	localparam int BIT_W = $clog2(VALUE_BITS);

	logic [VALUE_BITS-1:0] mag_q;
	logic [DIGIT_W-1:0]    rem_q;
	logic [BIT_W-1:0]      bit_q;
	logic [BASE_W-1:0]     trial;
	logic                  qbit;
	logic [DIGIT_W-1:0]    rem_next;
	logic [VALUE_BITS-1:0] mag_next;
	logic                  last_bit;

	// Restoring division: one quotient bit per cycle, quotient shifts in behind the dividend.
	assign trial    = {rem_q, mag_q[VALUE_BITS-1]};
	assign qbit     = (trial >= radix);
	assign rem_next = qbit ? DIGIT_W'(trial - radix) : trial[DIGIT_W-1:0];
	assign mag_next = {mag_q[VALUE_BITS-2:0], qbit};
	assign last_bit = (bit_q == BIT_W'(VALUE_BITS - 1));

	assign status.digit_done = run && last_bit;
	assign status.quot_zero  = (mag_next == '0);
	assign status.digit      = rem_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bit_q <= '0;
		end else if (load) begin
			bit_q <= '0;
		end else if (run) begin
			bit_q <= last_bit ? '0 : bit_q + 1'b1;
		end
	end

	// Datapath shift registers; the remainder restarts after each digit.
	always_ff @(posedge clk) begin
		if (load) begin
			mag_q <= mag;
			rem_q <= '0;
		end else if (run) begin
			mag_q <= mag_next;
			rem_q <= last_bit ? '0 : rem_next;
		end
	end

endmodule

### hdl/sirt_digit_ram.sv
module sirt_digit_ram import sirt_pkg::*; #(
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [DIGIT_W-1:0]       wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [DIGIT_W-1:0]       rdata
);

	logic [DIGIT_W-1:0] mem [DEPTH];

	// One write port, one registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

### tb/tb.sv
module tb;
	import sirt_pkg::*;

	localparam int VALUE_W      = 32;
	localparam int MAX_RADIX    = 16;
	localparam int CYCLE_LIMIT  = 1_000_000;
	localparam int HOLD_CYCLES  = 4000;
	localparam int QUIET_CYCLES = 8;
	localparam int TAIL_CYCLES  = 100;

	// One expected output character.
	typedef struct packed {
		logic [CHAR_W-1:0] ch;
		logic              last;
		logic              bad;
	} text_char_t;

	// Ways in which a random alphabet is broken.
	typedef enum int {
		BAD_RADIX,
		BAD_DUPLICATE,
		BAD_PLUS,
		BAD_MINUS,
		BAD_UNPRINTABLE
	} alphabet_fault_t;

	logic                      clk;
	logic                      arst_n;
	logic                      in_valid;
	logic                      in_ready;
	logic signed [VALUE_W-1:0] value;
	logic                      cfg_we;
	logic [CFG_IDX_W-1:0]      cfg_addr;
	logic [CFG_W-1:0]          cfg_wdata;
	logic                      out_valid;
	logic                      out_ready;
	logic [CHAR_W-1:0]         out_char;
	logic                      is_last;
	logic                      base_invalid;

	// Shadow copy of the configuration registers.
	logic [BASE_W-1:0] cfg_base;
	logic [CFG_W-1:0]  cfg_alpha_lo;
	logic [CFG_W-1:0]  cfg_alpha_hi;

	text_char_t text_expected[$];

	int  mismatches;
	int  numbers_sent;
	int  chars_checked;
	int  error_results;
	int  settings_used;
	int  cycle_count;
	int  hold_requests;
	bit  rx_stalls;
	bit  tx_gaps;
	bit  in_open;
	int  burst_left;

	signed_int_to_radix_text #(
		.MAX_BASE  (MAX_RADIX),
		.VALUE_BITS(VALUE_W)
	) i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.value       (value),
		.cfg_we      (cfg_we),
		.cfg_addr    (cfg_addr),
		.cfg_wdata   (cfg_wdata),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.out_char    (out_char),
		.is_last     (is_last),
		.base_invalid(base_invalid)
	);

	// Free-running clock.
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Cycle counter that ends a hung run.
	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Run exceeded %0d cycles.", CYCLE_LIMIT);
		$display("end of test: mismatches");
		$finish;
	end

	// Works out the characters that one number gives under the current settings.
	function automatic void predict_radix_text(input logic signed [VALUE_W-1:0] v);
		logic [ALPHA_W-1:0] alpha;
		logic [VALUE_W:0]   mag;
		logic [DIGIT_W-1:0] digits[VALUE_W];
		logic [CHAR_W-1:0]  c;
		int                 radix;
		int                 n;
		bit                 ok;
		alpha = {cfg_alpha_hi, cfg_alpha_lo};
		radix = int'(cfg_base);
		ok = (radix >= MIN_BASE) && (radix <= MAX_RADIX);
		// The alphabet check looks only at the characters in use.
		if (ok) begin
			for (int i = 0; i < radix; i++) begin
				c = alpha[i*CHAR_W +: CHAR_W];
				if (c == CH_PLUS || c == CH_MINUS || c < CH_SPACE || c > CH_TILDE)
					ok = 0;
				for (int j = 0; j < i; j++)
					if (alpha[j*CHAR_W +: CHAR_W] == c)
						ok = 0;
			end
		end
		if (!ok) begin
			text_expected.push_back('{ch: CH_NONE, last: 1'b1, bad: 1'b1});
			error_results++;
			return;
		end
		// The magnitude has one extra bit so the most negative value fits.
		if (v < 0) begin
			text_expected.push_back('{ch: CH_MINUS, last: 1'b0, bad: 1'b0});
			mag = {1'b0, ~v} + 1'b1;
		end else begin
			mag = {1'b0, v};
		end
		n = 0;
		do begin
			digits[n] = DIGIT_W'(mag % (VALUE_W+1)'(radix));
			n++;
			mag = mag / (VALUE_W+1)'(radix);
		end while (mag != 0 && n < VALUE_W);
		for (int k = n - 1; k >= 0; k--)
			text_expected.push_back('{ch: alpha[int'(digits[k])*CHAR_W +: CHAR_W],
				last: (k == 0), bad: 1'b0});
	endfunction

	// Picks a value: full range, small, extremes, near a power of the radix, or a random width.
	function automatic logic signed [VALUE_W-1:0] pick_value(input int radix);
		logic [VALUE_W-1:0] r;
		longint             p;
		case ($urandom_range(0, 4))
			0: begin
				r = $urandom;
			end
			1: begin
				r = VALUE_W'(int'($urandom_range(0, 80)) - 40);
			end
			2: begin
				case ($urandom_range(0, 3))
					0: r = 32'h8000_0000;
					1: r = 32'h8000_0001;
					2: r = 32'h7FFF_FFFF;
					default: r = 32'hFFFF_FFFF;
				endcase
			end
			3: begin
				p = 1;
				repeat ($urandom_range(1, 31))
					if (p * radix <= 64'h7FFF_FFFF)
						p = p * radix;
				p = p - 1 + $urandom_range(0, 2);
				r = VALUE_W'(p);
				if ($urandom_range(0, 1))
					r = -r;
			end
			default: begin
				r = $urandom >> $urandom_range(0, 31);
				if ($urandom_range(0, 1))
					r = ~r;
			end
		endcase
		return r;
	endfunction

	// Builds a random alphabet, either valid or with one fault.
	function automatic void make_alphabet(input bit want_valid, output logic [BASE_W-1:0] base,
		output logic [CFG_W-1:0] lo, output logic [CFG_W-1:0] hi);
		logic [CHAR_W-1:0] chars[MAX_RADIX];
		bit [255:0]        taken;
		logic [CHAR_W-1:0] c;
		alphabet_fault_t   fault;
		int                n;
		int                i;
		int                j;
		n = $urandom_range(MIN_BASE, MAX_RADIX);
		taken = '0;
		for (int k = 0; k < MAX_RADIX; k++) begin
			if (k < n) begin
				do
					c = CHAR_W'($urandom_range(32, 126));
				while (taken[c] || c == CH_PLUS || c == CH_MINUS);
				taken[c] = 1'b1;
				chars[k] = c;
			end else begin
				// Slots beyond the radix may hold anything.
				chars[k] = CHAR_W'($urandom);
			end
		end
		base = BASE_W'(n);
		if (!want_valid) begin
			fault = alphabet_fault_t'($urandom_range(0, 4));
			i = $urandom_range(1, n - 1);
			case (fault)
				BAD_RADIX: begin
					base = $urandom_range(0, 1) ? BASE_W'($urandom_range(0, 1))
						: BASE_W'($urandom_range(17, 31));
				end
				BAD_DUPLICATE: begin
					j = $urandom_range(0, i - 1);
					chars[i] = chars[j];
				end
				BAD_PLUS: begin
					chars[i] = CH_PLUS;
				end
				BAD_MINUS: begin
					chars[i] = CH_MINUS;
				end
				default: begin
					chars[i] = $urandom_range(0, 1) ? CHAR_W'($urandom_range(0, 31))
						: CHAR_W'($urandom_range(127, 255));
				end
			endcase
		end
		for (int k = 0; k < 8; k++) begin
			lo[k*CHAR_W +: CHAR_W] = chars[k];
			hi[k*CHAR_W +: CHAR_W] = chars[k+8];
		end
	endfunction

	// Lowers the input valid once the stream stops.
	task automatic input_idle();
		if (in_open)
			in_valid <= 1'b0;
		in_open = 0;
		@(posedge clk);
	endtask

	// Waits until every expected character has arrived and the block is quiet.
	task automatic drain_output();
		input_idle();
		while (text_expected.size() != 0)
			@(posedge clk);
		repeat (QUIET_CYCLES) @(posedge clk);
	endtask

	// Offers one number, with bursts and gaps, and predicts its text on acceptance.
	task automatic send_value(input logic signed [VALUE_W-1:0] v);
		int gap;
		gap = 0;
		if (tx_gaps) begin
			if (burst_left == 0) begin
				gap = $urandom_range(1, 12);
				burst_left = $urandom_range(1, 8);
			end
			burst_left--;
		end
		if (gap > 0) begin
			if (in_open)
				in_valid <= 1'b0;
			in_open = 0;
			repeat (gap) @(posedge clk);
		end
		value <= v;
		in_valid <= 1'b1;
		do
			@(posedge clk);
		while (!in_ready);
		in_open = 1;
		predict_radix_text(v);
		numbers_sent++;
	endtask

	// Writes one register and keeps the shadow copy in step.
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_addr <= idx;
		cfg_wdata <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_BASE_LENGTH:   cfg_base = data[BASE_W-1:0];
			REG_ALPHABET_LOW:  cfg_alpha_lo = data;
			REG_ALPHABET_HIGH: cfg_alpha_hi = data;
			default: ;
		endcase
	endtask

	// Loads a radix and an alphabet while the block is idle.
	task automatic configure(input logic [BASE_W-1:0] base, input logic [CFG_W-1:0] lo,
		input logic [CFG_W-1:0] hi);
		logic [CFG_W-1:0] junk;
		drain_output();
		junk = {$urandom, $urandom};
		write_reg(REG_BASE_LENGTH, {junk[CFG_W-1:BASE_W], base});
		write_reg(REG_ALPHABET_LOW, lo);
		write_reg(REG_ALPHABET_HIGH, hi);
		settings_used++;
	endtask

	// Decimal digits straight after reset, including zero and both extremes.
	task automatic test_default_decimal();
		tx_gaps = 1;
		rx_stalls = 1;
		send_value(32'sd0);
		send_value(32'sd1);
		send_value(-32'sd1);
		send_value(32'sh7FFF_FFFF);
		send_value(32'sh8000_0000);
		send_value(-32'sd10);
	endtask

	// Smallest and largest radix, and the outer printable characters.
	task automatic test_radix_extremes();
		configure(5'd16, 64'h3736_3534_3332_3130, 64'h6665_6463_6261_3938);
		send_value(32'shDEAD_BEEF);
		send_value(32'sh7FFF_FFFF);
		send_value(32'sh8000_0000);
		// Binary, with a plus sign and a zero byte in unused slots.
		configure(5'd2, 64'h0000_0000_002B_3130, 64'h0000_0000_0000_0000);
		send_value(32'sh8000_0000);
		send_value(32'sh7FFF_FFFF);
		send_value(32'sd5);
		// Space as the first digit and tilde as the last.
		configure(5'd16, 64'h2726_2524_2322_2120, 64'h7E30_2F2E_2C2A_2928);
		send_value(32'sd0);
		send_value(32'sd15);
		send_value(-32'sd16);
	endtask

	// Each kind of alphabet that fails the check gives one error character.
	task automatic test_bad_alphabets();
		configure(5'd0, ALPHA_LOW_RST, ALPHA_HI_RST);
		send_value(32'sd7);
		configure(5'd1, ALPHA_LOW_RST, ALPHA_HI_RST);
		send_value(32'sd0);
		configure(5'd17, ALPHA_LOW_RST, ALPHA_HI_RST);
		send_value(-32'sd3);
		configure(5'd31, ALPHA_LOW_RST, ALPHA_HI_RST);
		send_value(32'sh8000_0000);
		// Duplicate digit.
		configure(5'd10, ALPHA_LOW_RST, 64'h0000_0000_0000_3338);
		send_value(32'sd99);
		// Plus sign in use.
		configure(5'd10, 64'h3736_352B_3332_3130, ALPHA_HI_RST);
		send_value(32'sd12);
		// Minus sign in use.
		configure(5'd10, 64'h3736_3534_3332_312D, ALPHA_HI_RST);
		send_value(-32'sd12);
		// Control character below space.
		configure(5'd10, 64'h1F36_3534_3332_3130, ALPHA_HI_RST);
		send_value(32'sd1);
		// Delete character above tilde.
		configure(5'd10, ALPHA_LOW_RST, 64'h0000_0000_0000_7F38);
		send_value(32'sd2);
		// Zero byte inside the alphabet.
		configure(5'd10, ALPHA_LOW_RST, 64'h0000_0000_0000_0038);
		send_value(32'sd3);
	endtask

	// Long receiver hold-off while numbers keep coming, then a full drain.
	task automatic test_output_hold();
		configure(5'd2, 64'h0000_0000_0000_3130, 64'h0);
		tx_gaps = 0;
		rx_stalls = 0;
		hold_requests++;
		repeat (6) send_value(pick_value(2));
		drain_output();
	endtask

	// Random settings, mostly valid, with random numbers under each.
	task automatic test_random_numbers();
		logic [BASE_W-1:0] base;
		logic [CFG_W-1:0]  lo;
		logic [CFG_W-1:0]  hi;
		for (int phase = 0; phase < 8; phase++) begin
			make_alphabet($urandom_range(0, 99) < 80, base, lo, hi);
			configure(base, lo, hi);
			// One phase runs flat out on both sides.
			tx_gaps = (phase != 3);
			rx_stalls = (phase != 3) && ($urandom_range(0, 3) != 0);
			repeat (16) send_value(pick_value(int'(base)));
		end
	endtask

	// Receiver: runs of ready and stall, plus a long hold-off on request.
	initial begin
		int  hold_served;
		int  hold_left;
		int  run_left;
		bit  ready_phase;
		hold_served = 0;
		hold_left = 0;
		run_left = 0;
		ready_phase = 1'b1;
		out_ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_served != hold_requests) begin
				hold_served++;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else if (!rx_stalls) begin
				out_ready <= 1'b1;
			end else begin
				if (run_left == 0) begin
					ready_phase = ~ready_phase;
					run_left = ready_phase ? $urandom_range(1, 16) : $urandom_range(1, 6);
				end
				run_left--;
				out_ready <= ready_phase;
			end
		end
	end

	// Compares each output transaction with the oldest expected character.
	always @(posedge clk) begin
		text_char_t want;
		if (arst_n && out_valid && out_ready) begin
			chars_checked++;
			if (text_expected.size() == 0) begin
				$error("Unexpected character 0x%02h with nothing expected.", out_char);
				mismatches++;
			end else begin
				want = text_expected.pop_front();
				if (out_char !== want.ch) begin
					$error("out_char: expected 0x%02h, actual 0x%02h", want.ch, out_char);
					mismatches++;
				end
				if (is_last !== want.last) begin
					$error("is_last: expected %0b, actual %0b", want.last, is_last);
					mismatches++;
				end
				if (base_invalid !== want.bad) begin
					$error("base_invalid: expected %0b, actual %0b", want.bad, base_invalid);
					mismatches++;
				end
			end
		end
	end

	// Test sequence.
	initial begin
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		value <= '0;
		cfg_we <= 1'b0;
		cfg_addr <= REG_BASE_LENGTH;
		cfg_wdata <= '0;
		cfg_base = BASE_RST;
		cfg_alpha_lo = ALPHA_LOW_RST;
		cfg_alpha_hi = ALPHA_HI_RST;
		mismatches = 0;
		numbers_sent = 0;
		chars_checked = 0;
		error_results = 0;
		settings_used = 0;
		hold_requests = 0;
		rx_stalls = 0;
		tx_gaps = 0;
		in_open = 0;
		burst_left = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_default_decimal();
		test_radix_extremes();
		test_bad_alphabets();
		test_output_hold();
		test_random_numbers();

		drain_output();
		repeat (TAIL_CYCLES) @(posedge clk);
		$display("Sent %0d numbers under %0d settings plus the reset one.", numbers_sent,
			settings_used);
		$display("Checked %0d characters, %0d of them alphabet errors.", chars_checked,
			error_results);
		if (mismatches == 0 && text_expected.size() == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule

### signed_int_to_radix_text.f
hdl/sirt_pkg.sv
hdl/sirt_alpha_check.sv
hdl/sirt_divider.sv
hdl/sirt_digit_ram.sv
hdl/signed_int_to_radix_text.sv
tb/tb.sv
